/* sv/json5_string_unescape_utf8_assert.svh */
// assertion macros for the json5 string unescaper
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef JSON5_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON5_STRING_UNESCAPE_UTF8_ASSERT_SVH
`ifndef SYNTH
`define J5U_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
`define J5U_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
`define J5U_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define J5U_ASSERT(lbl, expr, msg)
`define J5U_ASSERT_IMP(lbl, pre, post, msg)
`define J5U_ASSERT_NXT(lbl, pre, post, msg)
`endif
`endif

/* sv/j5u_pkg.sv */
// types, constants and helper functions for the json5 string unescaper
// no dependencies
`default_nettype none

package j5u_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_TEXT    = 3'd1,
        MODE_ESC     = 3'd2,
        MODE_HEX     = 3'd3,
        MODE_WAIT_BS = 3'd4,
        MODE_WAIT_U  = 3'd5,
        MODE_LO_HEX  = 3'd6
    } t_mode;

    localparam logic [7:0]  CH_BSLASH    = 8'h5C;
    localparam logic [7:0]  CH_U         = 8'h75;
    localparam logic [5:0]  HI_SURR_TAG  = 6'b110110;  // d800..dbff
    localparam logic [5:0]  LO_SURR_TAG  = 6'b110111;  // dc00..dfff
    localparam logic [20:0] SUPP_BASE    = 21'h10000;
    localparam int unsigned MAX_RESULTS  = 4;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  term;
        logic [20:0] cp;
        logic [15:0] lo;
        logic [1:0]  digits;
    } t_state;

    // one result item, without its last flag
    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       done;
    } t_res;

    typedef struct packed {
        t_res [MAX_RESULTS-1:0] ent;
        logic [2:0]             cnt;
    } t_group;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } t_utf8;

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [3:0] v;
        v = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) v = 4'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66) v = 4'(b - 8'h57);
        else if (b >= 8'h41 && b <= 8'h46) v = 4'(b - 8'h37);
        return v;
    endfunction

    function automatic logic [7:0] esc_char(input logic [7:0] b);
        logic [7:0] c;
        case (b)
            8'h6E:   c = 8'h0A;  // n
            8'h74:   c = 8'h09;  // t
            8'h72:   c = 8'h0D;  // r
            8'h62:   c = 8'h08;  // b
            8'h66:   c = 8'h0C;  // f
            default: c = b;
        endcase
        return c;
    endfunction

    function automatic t_utf8 utf8_enc(input logic [20:0] c);
        t_utf8 u;
        u.bytes = '0;
        if (c[20:7] == '0) begin
            u.len      = 3'd1;
            u.bytes[0] = {1'b0, c[6:0]};
        end else if (c[20:11] == '0) begin
            u.len      = 3'd2;
            u.bytes[0] = {3'b110, c[10:6]};
            u.bytes[1] = {2'b10, c[5:0]};
        end else if (c[20:16] == '0) begin
            u.len      = 3'd3;
            u.bytes[0] = {4'b1110, c[15:12]};
            u.bytes[1] = {2'b10, c[11:6]};
            u.bytes[2] = {2'b10, c[5:0]};
        end else begin
            u.len      = 3'd4;
            u.bytes[0] = {5'b11110, c[20:18]};
            u.bytes[1] = {2'b10, c[17:12]};
            u.bytes[2] = {2'b10, c[11:6]};
            u.bytes[3] = {2'b10, c[5:0]};
        end
        return u;
    endfunction

endpackage

`default_nettype wire

/* sv/j5u_decode.sv */
// single-pass decode of one input byte: next state and the group of result items
// depends on j5u_pkg
`default_nettype none

module j5u_decode
    import j5u_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_data,
    input  logic       i_opens,
    input  logic       i_eoi,
    output t_state     o_state,
    output t_group     o_grp
);

    logic        enc_v;
    logic [20:0] enc_cp;
    t_utf8       enc;
    logic        tail_v;
    t_res        tail;
    logic [3:0]  nib;
    logic [15:0] acc_sh;
    logic [15:0] lo_sh;
    logic [20:0] pair_cp;
    logic [2:0]  enc_len;

    assign nib     = hex_val(i_data);
    assign acc_sh  = {i_state.cp[11:0], nib};
    assign lo_sh   = {i_state.lo[11:0], nib};
    // high surrogate sits in cp, so its offset from d800 is its low ten bits
    assign pair_cp = SUPP_BASE + {1'b0, i_state.cp[9:0], lo_sh[9:0]};

    always_comb begin
        o_state = i_state;
        enc_v   = 1'b0;
        enc_cp  = i_state.cp;
        tail_v  = 1'b0;
        tail    = '0;
        if (i_eoi || i_opens) begin
            // close whatever is open
            case (i_state.mode)
                MODE_TEXT, MODE_ESC: begin
                    tail_v = 1'b1;
                    tail.done = 1'b1;
                end
                MODE_HEX, MODE_WAIT_BS, MODE_WAIT_U, MODE_LO_HEX: begin
                    enc_v  = 1'b1;
                    tail_v = 1'b1;
                    tail.done = 1'b1;
                end
                default: ;
            endcase
            o_state.mode = MODE_IDLE;
            if (!i_eoi) begin
                o_state.term   = i_data;
                o_state.cp     = '0;
                o_state.lo     = '0;
                o_state.digits = '0;
                o_state.mode   = MODE_TEXT;
            end
        end else begin
            case (i_state.mode)
                MODE_TEXT, MODE_WAIT_BS: begin
                    if (i_state.mode == MODE_WAIT_BS && i_data == CH_BSLASH) begin
                        o_state.mode = MODE_WAIT_U;
                    end else begin
                        // lone high surrogate goes out ahead of the byte
                        enc_v = (i_state.mode == MODE_WAIT_BS);
                        if (i_data == i_state.term) begin
                            tail_v = 1'b1;
                            tail.done = 1'b1;
                            o_state.mode = MODE_IDLE;
                        end else if (i_data == CH_BSLASH) begin
                            o_state.mode = MODE_ESC;
                        end else begin
                            tail_v = 1'b1;
                            tail.data = i_data;
                            tail.byte_valid = 1'b1;
                            o_state.mode = MODE_TEXT;
                        end
                    end
                end
                MODE_ESC, MODE_WAIT_U: begin
                    if (i_data == CH_U) begin
                        if (i_state.mode == MODE_ESC) begin
                            o_state.mode = MODE_HEX;
                            o_state.cp   = '0;
                        end else begin
                            o_state.mode = MODE_LO_HEX;
                            o_state.lo   = '0;
                        end
                        o_state.digits = '0;
                    end else begin
                        enc_v = (i_state.mode == MODE_WAIT_U);
                        tail_v = 1'b1;
                        tail.data = esc_char(i_data);
                        tail.byte_valid = 1'b1;
                        o_state.mode = MODE_TEXT;
                    end
                end
                MODE_HEX: begin
                    o_state.cp     = {5'd0, acc_sh};
                    o_state.digits = i_state.digits + 2'd1;
                    if (i_state.digits == 2'd3) begin
                        if (acc_sh[15:10] == HI_SURR_TAG) begin
                            o_state.mode = MODE_WAIT_BS;
                        end else begin
                            enc_v  = 1'b1;
                            enc_cp = {5'd0, acc_sh};
                            o_state.mode = MODE_TEXT;
                        end
                    end
                end
                MODE_LO_HEX: begin
                    o_state.lo     = lo_sh;
                    o_state.digits = i_state.digits + 2'd1;
                    if (i_state.digits == 2'd3) begin
                        enc_v = 1'b1;
                        if (lo_sh[15:10] == LO_SURR_TAG) begin
                            enc_cp     = pair_cp;
                            o_state.cp = pair_cp;
                        end
                        o_state.mode = MODE_TEXT;
                    end
                end
                default: begin
                    o_state.mode = MODE_IDLE;
                end
            endcase
        end
    end

    assign enc     = utf8_enc(enc_cp);
    assign enc_len = enc_v ? enc.len : 3'd0;

    // encoded bytes first, then the single trailing item
    always_comb begin
        o_grp.ent = '0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (3'(k) < enc_len) begin
                o_grp.ent[k].data       = enc.bytes[k];
                o_grp.ent[k].byte_valid = 1'b1;
            end else if (3'(k) == enc_len && tail_v) begin
                o_grp.ent[k] = tail;
            end
        end
        o_grp.cnt = enc_len + {2'd0, tail_v};
    end

endmodule

`default_nettype wire

/* sv/json5_string_unescape_utf8.sv */
// top level of the json5 string unescaper: input register, decode, result group serializer
// depends on j5u_pkg, j5u_decode and json5_string_unescape_utf8_assert.svh
//
// channel   dir  tdata                tuser                          tlast
// s (in)    in   [7:0] data_byte      [0] opens                      end_of_input
// m (out)   out  [7:0] out_byte       [0] byte_valid [1] string_done last result of request
//
// a request is registered, decoded in the following cycle and its results (0 to 4) are
// loaded into a group register; one request per cycle while each gives at most one result
// and the output is ready; results leave the group register singly; it is the limit
// while a group drains, requests with no results still pass; the first request with results
// waits in the input register and the input stalls until the group's final item leaves
// i_rst_n is synchronous and active low; it returns the decoder to idle with no string open
`default_nettype none
`include "json5_string_unescape_utf8_assert.svh"

module json5_string_unescape_utf8
    import j5u_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic [0:0] i_s_tuser,   // [0] opens
    input  logic       i_s_tlast,   // end_of_input
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic [1:0] o_m_tuser,   // [0] byte_valid, [1] string_done
    output logic       o_m_tlast    // last result of the request
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_opens;
    logic       r_in_eoi;

    // decoder state and result group
    t_state     r_state;
    t_state     n_state;
    t_group     n_grp;
    t_res [MAX_RESULTS-1:0] r_ent;
    logic [2:0] r_left;
    logic [1:0] r_idx;

    logic       w_out_fire;
    logic       w_grp_free;
    logic       w_consume;
    t_res       w_cur;

    j5u_decode u_decode (
        .i_state (r_state),
        .i_data  (r_in_data),
        .i_opens (r_in_opens),
        .i_eoi   (r_in_eoi),
        .o_state (n_state),
        .o_grp   (n_grp)
    );

    assign w_out_fire = o_m_tvalid && i_m_tready;
    // group register can take a new group when empty or when its final item leaves now
    assign w_grp_free = (r_left == 3'd0) || (r_left == 3'd1 && w_out_fire);
    // a request with no results never needs the group register
    assign w_consume  = r_in_valid && (w_grp_free || n_grp.cnt == 3'd0);
    assign o_s_tready = !r_in_valid || w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // payload of the input register
    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_in_data  <= i_s_tdata;
            r_in_opens <= i_s_tuser[0];
            r_in_eoi   <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: MODE_IDLE, term: '0, cp: '0, lo: '0, digits: '0};
        end else if (w_consume) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
            r_idx  <= 2'd0;
        end else if (w_consume && n_grp.cnt != 3'd0) begin
            r_left <= n_grp.cnt;
            r_idx  <= 2'd0;
        end else if (w_out_fire) begin
            r_left <= r_left - 3'd1;
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume && n_grp.cnt != 3'd0) begin
            r_ent <= n_grp.ent;
        end
    end

    assign w_cur      = r_ent[r_idx];
    assign o_m_tvalid = (r_left != 3'd0);
    assign o_m_tdata  = w_cur.data;
    assign o_m_tuser  = {w_cur.done, w_cur.byte_valid};
    assign o_m_tlast  = (r_left == 3'd1);

    // a group never holds more than four results
    `J5U_ASSERT(a_left_max, r_left <= 3'd4, "result group count above four")
    // the end marker of a string carries no byte
    `J5U_ASSERT_IMP(a_done_no_byte, o_m_tvalid && o_m_tuser[1], !o_m_tuser[0], "marker with byte")
    // a held input request stays in the register
    `J5U_ASSERT_NXT(a_in_hold, r_in_valid && !w_consume, r_in_valid, "held request lost")
    // the index walks the group from the start: remaining plus taken is at most four
    `J5U_ASSERT(a_idx_range, ({1'b0, r_idx} + r_left) <= 3'd4, "group index past group end")

endmodule

`default_nettype wire

/* test/tb_top.sv */
// testbench for json5_string_unescape_utf8: table-driven and random byte streams are checked
// against a behavioral unescaper or typed rows, with random idling on both stream sides
// depends on j5u_pkg and the json5_string_unescape_utf8 top level

module tb_top
    import j5u_pkg::*;
();

    // one output result of the unescaper
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       done;
        logic       last;
    } t_utf8_res;

    // directed row; typed rows carry at most one result written out by hand
    typedef struct packed {
        logic [7:0] data;
        logic       op;
        logic       eoi;
        logic       typed;
        logic       has_res;
        logic [7:0] res_byte;
        logic       res_valid;
        logic       res_done;
    } t_dir_row;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    localparam logic [7:0] ESC_CHARS [9] = '{"n", "t", "r", "b", "f", "/",
                                             CH_BSLASH, CH_DQUOTE, CH_SQUOTE};
    localparam logic [15:0] EDGE_CP [6] = '{16'h0000, 16'h007F, 16'h0080,
                                            16'h07FF, 16'h0800, 16'hFFFF};

    localparam t_dir_row DIRECTED [32] = '{
        '{"x",       1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},  // byte while idle
        '{8'hA5,     1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},  // end while idle
        '{CH_DQUOTE, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},  // open
        '{8'h00,     1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b1, 1'b0},
        '{8'hFF,     1'b0, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0},
        '{CH_BSLASH, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"n",       1'b0, 1'b0, 1'b1, 1'b1, 8'h0A, 1'b1, 1'b0},
        '{CH_BSLASH, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{CH_U,      1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"D",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // high surrogate d800
        '{"8",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"0",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"0",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"q",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // no \u follows: lone high
        '{CH_BSLASH, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{CH_U,      1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"d",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // dbff, mixed case digits
        '{"B",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"f",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"F",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{CH_U,      1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"D",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // dfff: top code point
        '{"F",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"F",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"F",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{CH_BSLASH, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{CH_U,      1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{"7",       1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{CH_SQUOTE, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // reopen inside hex digits
        '{CH_BSLASH, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{8'h5A,     1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1}   // end after lone backslash
    };

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
    logic [0:0] s_tuser  = 1'b0;    // [0] opens
    logic       s_tlast  = 1'b0;    // end_of_input
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic [1:0] m_tuser;            // [0] byte_valid, [1] string_done
    logic       m_tlast;            // last result of the request

    int idle_pct     = 0;
    int stall_pct    = 0;
    int fail_count   = 0;
    int payload_reqs = 0;

    t_utf8_res pending_utf8 [$];

    // unescaper state as seen from outside
    t_mode       dec_mode  = MODE_IDLE;
    logic [7:0]  str_quote = 8'h00;
    logic [20:0] cp_acc    = '0;
    logic [15:0] lo_acc    = '0;
    logic [2:0]  digit_cnt = '0;

    t_utf8_res step_res [4];
    int        step_n;

    json5_string_unescape_utf8 i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // ---- behavioral unescaper ----

    function void put_res(input logic [7:0] b, input logic v, input logic d);
        t_utf8_res r;
        if (step_n < 4) begin
            r.data = b;
            r.valid = v;
            r.done = d;
            r.last = 1'b0;
            step_res[step_n] = r;
            step_n++;
        end
    endfunction

    function void put_utf8(input logic [20:0] c);
        if (c < 21'h80) begin
            put_res(c[7:0], 1'b1, 1'b0);
        end else if (c < 21'h800) begin
            put_res(8'hC0 | 8'(c >> 6), 1'b1, 1'b0);
            put_res(8'h80 | 8'(c & 21'h3F), 1'b1, 1'b0);
        end else if (c < 21'h10000) begin
            put_res(8'hE0 | 8'(c >> 12), 1'b1, 1'b0);
            put_res(8'h80 | 8'((c >> 6) & 21'h3F), 1'b1, 1'b0);
            put_res(8'h80 | 8'(c & 21'h3F), 1'b1, 1'b0);
        end else begin
            put_res(8'hF0 | 8'((c >> 18) & 21'h7), 1'b1, 1'b0);
            put_res(8'h80 | 8'((c >> 12) & 21'h3F), 1'b1, 1'b0);
            put_res(8'h80 | 8'((c >> 6) & 21'h3F), 1'b1, 1'b0);
            put_res(8'h80 | 8'(c & 21'h3F), 1'b1, 1'b0);
        end
    endfunction

    // non-hex bytes read as zero
    function logic [3:0] nibble_of(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        if (b >= "0" && b <= "9") n = 4'(b - "0");
        else if (b >= "a" && b <= "f") n = 4'(b - "a" + 8'd10);
        else if (b >= "A" && b <= "F") n = 4'(b - "A" + 8'd10);
        return n;
    endfunction

    function void text_in(input logic [7:0] b);
        if (b == str_quote) begin
            put_res(8'h00, 1'b0, 1'b1);
            dec_mode = MODE_IDLE;
        end else if (b == CH_BSLASH) begin
            dec_mode = MODE_ESC;
        end else begin
            put_res(b, 1'b1, 1'b0);
            dec_mode = MODE_TEXT;
        end
    endfunction

    function void esc_in(input logic [7:0] b);
        logic [7:0] ch;
        ch = b;
        case (b)
            "n": ch = 8'h0A;
            "t": ch = 8'h09;
            "r": ch = 8'h0D;
            "b": ch = 8'h08;
            "f": ch = 8'h0C;
            CH_U: begin
                dec_mode = MODE_HEX;
                cp_acc = '0;
                digit_cnt = '0;
                return;
            end
            default: ;
        endcase
        put_res(ch, 1'b1, 1'b0);
        dec_mode = MODE_TEXT;
    endfunction

    // flush whatever code point is in flight, then the end marker
    function void close_str();
        case (dec_mode)
            MODE_TEXT, MODE_ESC: ;
            MODE_HEX, MODE_WAIT_BS, MODE_WAIT_U, MODE_LO_HEX: put_utf8(cp_acc);
            default: begin
                dec_mode = MODE_IDLE;
                return;
            end
        endcase
        put_res(8'h00, 1'b0, 1'b1);
        dec_mode = MODE_IDLE;
    endfunction

    function void unescape_byte(input logic [7:0] b, input logic op, input logic eoi);
        step_n = 0;
        if (eoi) begin
            close_str();
        end else if (op) begin
            close_str();
            str_quote = b;
            cp_acc = '0;
            lo_acc = '0;
            digit_cnt = '0;
            dec_mode = MODE_TEXT;
        end else begin
            case (dec_mode)
                MODE_TEXT: text_in(b);
                MODE_ESC:  esc_in(b);
                MODE_HEX: begin
                    cp_acc = {5'd0, cp_acc[11:0], nibble_of(b)};
                    digit_cnt = digit_cnt + 3'd1;
                    if (digit_cnt >= 3'd4) begin
                        digit_cnt = '0;
                        if (cp_acc >= 21'hD800 && cp_acc <= 21'hDBFF) begin
                            dec_mode = MODE_WAIT_BS;
                        end else begin
                            put_utf8(cp_acc);
                            dec_mode = MODE_TEXT;
                        end
                    end
                end
                MODE_WAIT_BS: begin
                    if (b == CH_BSLASH) begin
                        dec_mode = MODE_WAIT_U;
                    end else begin
                        put_utf8(cp_acc);
                        text_in(b);
                    end
                end
                MODE_WAIT_U: begin
                    if (b == CH_U) begin
                        lo_acc = '0;
                        digit_cnt = '0;
                        dec_mode = MODE_LO_HEX;
                    end else begin
                        put_utf8(cp_acc);
                        esc_in(b);
                    end
                end
                MODE_LO_HEX: begin
                    lo_acc = {lo_acc[11:0], nibble_of(b)};
                    digit_cnt = digit_cnt + 3'd1;
                    if (digit_cnt >= 3'd4) begin
                        digit_cnt = '0;
                        // a bad low half is dropped and the high half goes out alone
                        if (lo_acc >= 16'hDC00 && lo_acc <= 16'hDFFF)
                            cp_acc = SUPP_BASE + ((cp_acc - 21'hD800) << 10)
                                     + 21'(lo_acc - 16'hDC00);
                        put_utf8(cp_acc);
                        dec_mode = MODE_TEXT;
                    end
                end
                default: dec_mode = MODE_IDLE;
            endcase
        end
        if (step_n > 0) step_res[step_n - 1].last = 1'b1;
    endfunction

    // ---- stimulus ----

    task automatic send_req(input logic [7:0] b, input logic op, input logic eoi,
                            input logic predicted);
        int i;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= op;
        s_tlast  <= eoi;
        do @(posedge clk); while (!s_tready);
        unescape_byte(b, op, eoi);
        if (predicted)
            for (i = 0; i < step_n; i++) pending_utf8.push_back(step_res[i]);
        payload_reqs++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_req(b, 1'b0, 1'b0, 1'b1);
    endtask

    // data and opens are don't-care here, so they toggle freely
    task automatic send_end();
        send_req(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1, 1'b1);
    endtask

    task automatic send_u();
        send_byte(CH_BSLASH);
        send_byte(CH_U);
    endtask

    function logic [7:0] hex_ascii(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) c = "0" + 8'(nib);
        else if ($urandom_range(1) == 1) c = "A" + 8'(nib) - 8'd10;
        else c = "a" + 8'(nib) - 8'd10;
        return c;
    endfunction

    // leading ndig digits of v, now and then a junk byte in place of one
    task automatic send_hex(input logic [15:0] v, input int ndig);
        logic [7:0] ch;
        int i;
        for (i = 0; i < ndig; i++) begin
            ch = hex_ascii(v[15 - 4*i -: 4]);
            if ($urandom_range(15) == 0) ch = 8'($urandom_range(255));
            send_byte(ch);
        end
    endtask

    function logic [7:0] plain_byte(input logic [7:0] q);
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == q || b == CH_BSLASH) b = (q == 8'h20) ? 8'h21 : 8'h20;
        return b;
    endfunction

    task automatic random_string();
        logic [7:0] q;
        logic [15:0] v;
        int i;
        int pieces;
        if ($urandom_range(19) == 0) q = 8'($urandom_range(255));
        else q = ($urandom_range(1) == 1) ? CH_DQUOTE : CH_SQUOTE;
        send_req(q, 1'b1, 1'b0, 1'b1);
        pieces = $urandom_range(1, 6);
        for (i = 0; i < pieces; i++) begin
            case ($urandom_range(9))
                0, 1, 2: send_byte(plain_byte(q));
                3, 4: begin
                    send_byte(CH_BSLASH);
                    if ($urandom_range(4) == 0) send_byte(8'($urandom_range(255)));
                    else send_byte(ESC_CHARS[$urandom_range(8)]);
                end
                5, 6: begin
                    case ($urandom_range(3))
                        0: v = 16'($urandom_range(16'h7F));
                        1: v = 16'($urandom_range(16'h80, 16'h7FF));
                        2: v = 16'($urandom_range(16'h800, 16'hFFFF));
                        default: v = EDGE_CP[$urandom_range(5)];
                    endcase
                    send_u();
                    send_hex(v, 4);
                end
                7, 8: begin
                    send_u();
                    send_hex(16'($urandom_range(16'hD800, 16'hDBFF)), 4);
                    case ($urandom_range(7))
                        0: send_byte(plain_byte(q));
                        1: begin
                            send_byte(CH_BSLASH);
                            send_byte(ESC_CHARS[$urandom_range(8)]);
                        end
                        2: begin
                            if ($urandom_range(1) == 1) v = 16'($urandom_range(16'hDBFF));
                            else v = 16'($urandom_range(16'hE000, 16'hFFFF));
                            send_u();
                            send_hex(v, 4);
                        end
                        default: begin
                            send_u();
                            send_hex(16'($urandom_range(16'hDC00, 16'hDFFF)), 4);
                        end
                    endcase
                end
                default: begin
                    send_u();
                    repeat (4) send_byte(8'($urandom_range(255)));
                end
            endcase
        end
        case ($urandom_range(19))
            13, 14: send_end();
            15, 16: ;  // left open, the next string reopens it
            17: begin
                send_byte(CH_BSLASH);
                send_end();
            end
            18: begin
                send_u();
                send_hex(16'($urandom), $urandom_range(3));
                send_end();
            end
            19: begin
                send_u();
                send_hex(16'($urandom_range(16'hD800, 16'hDBFF)), 4);
                case ($urandom_range(2))
                    0: ;
                    1: send_byte(CH_BSLASH);
                    default: begin
                        send_u();
                        send_hex(16'($urandom_range(16'hDC00, 16'hDFFF)), $urandom_range(3));
                    end
                endcase
                send_end();
            end
            default: send_byte(q);
        endcase
    endtask

    // ---- checking ----

    function void check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk) begin : result_check
        t_utf8_res want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_utf8.size() == 0) begin
                $display("%0t: unexpected request, expected none, actual byte %h user %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                fail_count++;
            end else begin
                want = pending_utf8.pop_front();
                check_field("out_byte", want.data, m_tdata);
                check_field("byte_valid", 8'(want.valid), 8'(m_tuser[0]));
                check_field("string_done", 8'(want.done), 8'(m_tuser[1]));
                check_field("last", 8'(want.last), 8'(m_tlast));
            end
        end
    end

    initial begin : run
        t_dir_row row;
        t_utf8_res typed_res;
        int i;
        int ph;
        int phase_start;
        int saved;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < $size(DIRECTED); i++) begin
            row = DIRECTED[i];
            send_req(row.data, row.op, row.eoi, !row.typed);
            if (row.typed && row.has_res) begin
                typed_res.data = row.res_byte;
                typed_res.valid = row.res_valid;
                typed_res.done = row.res_done;
                typed_res.last = 1'b1;
                pending_utf8.push_back(typed_res);
            end
        end

        // idling phases: none, sender only, receiver only, both
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 72; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 72; end
                default: begin idle_pct = 34; stall_pct = 34; end
            endcase
            phase_start = payload_reqs;
            // random strings until the phase has sent at least six requests
            while (payload_reqs - phase_start < 6) begin
                if ($urandom_range(7) == 0) begin
                    // loose noise requests, not counted toward the phase
                    saved = payload_reqs;
                    repeat ($urandom_range(1, 4))
                        send_req(8'($urandom_range(255)), $urandom_range(7) == 0,
                                 $urandom_range(7) == 0, 1'b1);
                    payload_reqs = saved;
                end else begin
                    random_string();
                end
            end
        end
        s_tvalid <= 1'b0;

        while (pending_utf8.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
